// File: hdl/two_level_name_table_assert.svh
// ----------------------------------------------------------------------------
// two_level_name_table assertion macros
// Shared concurrent assertion forms for the name table checker.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_NAME_TABLE_ASSERT_SVH
`define TWO_LEVEL_NAME_TABLE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define TLNT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define TLNT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tlnt_pkg.sv
// ----------------------------------------------------------------------------
// tlnt_pkg
// Types, opcodes, status codes and default sizes of the two-level name table.
// ----------------------------------------------------------------------------
package tlnt_pkg;

    localparam int KEY_W = 64;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;

    localparam int DEF_MAX_DIRS  = 16;
    localparam int DEF_MAX_FILES = 16;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [OP_W-1:0]  t_opcode;
    typedef logic [ST_W-1:0]  t_status;

    // request opcodes
    localparam t_opcode OP_MKDIR  = 2'd0;
    localparam t_opcode OP_MKFILE = 2'd1;
    localparam t_opcode OP_DELETE = 2'd2;
    localparam t_opcode OP_SEARCH = 2'd3;

    // result status codes
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_NO_DIR     = 3'd1;
    localparam t_status ST_NO_FILE    = 3'd2;
    localparam t_status ST_DIRS_FULL  = 3'd3;
    localparam t_status ST_FILES_FULL = 3'd4;

endpackage

// File: hdl/tlnt_ram.sv
// ----------------------------------------------------------------------------
// tlnt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tlnt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/two_level_name_table.sv
// ----------------------------------------------------------------------------
// two_level_name_table
// Directory / file name table: create directory, create, delete and search
// file, one status beat per request.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   i_opcode, i_dir_key, i_file_key         start && !busy
//  result    o_status                                o_valid, one cycle
//
//  create directory answers straight from idle; other requests walk
//  the sequencer: directory names compared one by one, the file count
//  fetched, file names compared one by one and, on delete, the last file
//  moved into the hole, each name read through the single read port of
//  its name RAM. Requests answered straight from idle never raise busy.
//  busy stays high from the accepted beat until the result beat.
//  i_rst_n is synchronous; it empties the directory table, RAM contents
//  are left as they are. The receiver cannot stall o_valid.
// ----------------------------------------------------------------------------
module two_level_name_table
    import tlnt_pkg::*;
#(
    parameter int MAX_DIRS  = DEF_MAX_DIRS,
    parameter int MAX_FILES = DEF_MAX_FILES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_opcode i_opcode,
    input  t_key    i_dir_key,
    input  t_key    i_file_key,
    output logic    o_valid,
    output t_status o_status
);

    localparam int DIW = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
    localparam int DCW = $clog2(MAX_DIRS + 1);
    localparam int FCW = $clog2(MAX_FILES + 1);
    localparam int NSLOT = MAX_DIRS * MAX_FILES;
    localparam int FAW = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DSCAN = 3'd1;
    localparam logic [2:0] S_FCNT  = 3'd2;
    localparam logic [2:0] S_FSCAN = 3'd3;
    localparam logic [2:0] S_MOVE  = 3'd4;

    logic [2:0]     r_state, n_state;
    t_opcode        r_op, n_op;
    t_key           r_dkey, n_dkey;
    t_key           r_fkey, n_fkey;
    logic [DCW-1:0] r_dcnt, n_dcnt;
    logic [DCW-1:0] r_idx, n_idx;
    logic [FAW-1:0] r_base, n_base;
    logic [FCW-1:0] r_nf, n_nf;
    logic [FCW-1:0] r_fidx, n_fidx;
    logic           r_valid, n_valid;
    t_status        r_status, n_status;

    // ram ports
    logic           dn_we;
    logic [DIW-1:0] dn_waddr, dn_raddr;
    t_key           dn_wdata, dn_rdata;
    logic           fc_we;
    logic [DIW-1:0] fc_waddr, fc_raddr;
    logic [FCW-1:0] fc_wdata, fc_rdata;
    logic           fn_we;
    logic [FAW-1:0] fn_waddr, fn_raddr;
    t_key           fn_wdata, fn_rdata;

    // directory names
    tlnt_ram #(.WIDTH(KEY_W), .DEPTH(MAX_DIRS)) u_dir_names (
        .i_clk   (i_clk),
        .i_we    (dn_we),
        .i_waddr (dn_waddr),
        .i_wdata (dn_wdata),
        .i_raddr (dn_raddr),
        .o_rdata (dn_rdata)
    );

    // file count per directory
    tlnt_ram #(.WIDTH(FCW), .DEPTH(MAX_DIRS)) u_file_counts (
        .i_clk   (i_clk),
        .i_we    (fc_we),
        .i_waddr (fc_waddr),
        .i_wdata (fc_wdata),
        .i_raddr (fc_raddr),
        .o_rdata (fc_rdata)
    );

    // file names, MAX_FILES slots per directory
    tlnt_ram #(.WIDTH(KEY_W), .DEPTH(NSLOT)) u_file_names (
        .i_clk   (i_clk),
        .i_we    (fn_we),
        .i_waddr (fn_waddr),
        .i_wdata (fn_wdata),
        .i_raddr (fn_raddr),
        .o_rdata (fn_rdata)
    );

    // sequencer and name compares
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_dkey   = r_dkey;
        n_fkey   = r_fkey;
        n_dcnt   = r_dcnt;
        n_idx    = r_idx;
        n_base   = r_base;
        n_nf     = r_nf;
        n_fidx   = r_fidx;
        n_valid  = 1'b0;
        n_status = r_status;
        dn_we    = 1'b0;
        dn_waddr = r_dcnt[DIW-1:0];
        dn_wdata = i_dir_key;
        dn_raddr = '0;
        fc_we    = 1'b0;
        fc_waddr = r_idx[DIW-1:0];
        fc_wdata = '0;
        fc_raddr = r_idx[DIW-1:0];
        fn_we    = 1'b0;
        fn_waddr = r_base + FAW'(r_fidx);
        fn_wdata = fn_rdata;
        fn_raddr = r_base;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_opcode;
                    n_dkey = i_dir_key;
                    n_fkey = i_file_key;
                    n_idx  = '0;
                    if (i_opcode == OP_MKDIR) begin
                        n_valid = 1'b1;
                        if (r_dcnt == DCW'(MAX_DIRS)) begin
                            n_status = ST_DIRS_FULL;
                        end else begin
                            // append directory with an empty file list
                            dn_we    = 1'b1;
                            fc_we    = 1'b1;
                            fc_waddr = r_dcnt[DIW-1:0];
                            fc_wdata = '0;
                            n_dcnt   = r_dcnt + 1'b1;
                            n_status = ST_OK;
                        end
                    end else if (r_dcnt == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_NO_DIR;
                    end else begin
                        dn_raddr = '0;
                        n_state  = S_DSCAN;
                    end
                end
            end
            S_DSCAN: begin
                if (dn_rdata == r_dkey) begin
                    fc_raddr = r_idx[DIW-1:0];
                    n_base   = FAW'(r_idx[DIW-1:0]) * FAW'(MAX_FILES);
                    n_state  = S_FCNT;
                end else if (r_idx + 1'b1 == r_dcnt) begin
                    n_valid  = 1'b1;
                    n_status = ST_NO_DIR;
                    n_state  = S_IDLE;
                end else begin
                    n_idx    = r_idx + 1'b1;
                    dn_raddr = n_idx[DIW-1:0];
                end
            end
            S_FCNT: begin
                n_nf   = fc_rdata;
                n_fidx = '0;
                if (r_op == OP_MKFILE) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (fc_rdata == FCW'(MAX_FILES)) begin
                        n_status = ST_FILES_FULL;
                    end else begin
                        // append file at the end of the list
                        fn_we    = 1'b1;
                        fn_waddr = r_base + FAW'(fc_rdata);
                        fn_wdata = r_fkey;
                        fc_we    = 1'b1;
                        fc_wdata = fc_rdata + 1'b1;
                        n_status = ST_OK;
                    end
                end else if (fc_rdata == '0) begin
                    n_valid  = 1'b1;
                    n_status = ST_NO_FILE;
                    n_state  = S_IDLE;
                end else begin
                    fn_raddr = r_base;
                    n_state  = S_FSCAN;
                end
            end
            S_FSCAN: begin
                if (fn_rdata == r_fkey) begin
                    if (r_op == OP_SEARCH) begin
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_state  = S_IDLE;
                    end else begin
                        // fetch the last file to fill the hole
                        fn_raddr = r_base + FAW'(r_nf - 1'b1);
                        n_state  = S_MOVE;
                    end
                end else if (r_fidx + 1'b1 == r_nf) begin
                    n_valid  = 1'b1;
                    n_status = ST_NO_FILE;
                    n_state  = S_IDLE;
                end else begin
                    n_fidx   = r_fidx + 1'b1;
                    fn_raddr = r_base + FAW'(n_fidx);
                end
            end
            S_MOVE: begin
                fn_we    = 1'b1;
                fn_wdata = fn_rdata;
                fc_we    = 1'b1;
                fc_wdata = r_nf - 1'b1;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_dcnt  <= n_dcnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_dkey   <= n_dkey;
        r_fkey   <= n_fkey;
        r_idx    <= n_idx;
        r_base   <= n_base;
        r_nf     <= n_nf;
        r_fidx   <= n_fidx;
        r_status <= n_status;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule

// File: hdl/tlnt_checker.sv
// ----------------------------------------------------------------------------
// tlnt_checker
// Port-level checks on the name table's request and result beats.
// ----------------------------------------------------------------------------
`include "two_level_name_table_assert.svh"

module tlnt_checker
    import tlnt_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_valid,
    input t_status o_status
);

    logic accepted;
    logic status_known;

    // request beat and defined status range
    assign accepted     = start && !busy;
    assign status_known = (o_status <= ST_FILES_FULL);

    // an accepted request either answers at once or holds busy
    `TLNT_ASSERT_NXT(a_accept_progress, i_clk, i_rst_n, accepted, busy || o_valid, "request lost")

    // the result beat ends the busy span
    `TLNT_ASSERT_IMP(a_valid_not_busy, i_clk, i_rst_n, o_valid, !busy, "result beat while busy")

    // a result beat follows a request or a busy cycle
    `TLNT_ASSERT_IMP(a_valid_has_cause, i_clk, i_rst_n, o_valid, $past(busy || start), "no cause")

    // only defined status codes leave the block
    `TLNT_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_valid, status_known, "undefined status code")

endmodule

bind two_level_name_table tlnt_checker u_tlnt_checker (.*);
